@@ design/tsk_pkg.sv @@
// Package for the topological sort unit.
// Holds port widths, the default vertex limit and the in-degree lane control type.
// No dependencies.
package tsk_pkg;

    // Fixed widths of the transaction fields
    localparam int VTX_W = 6;
    localparam int ROW_W = 64;

    // Default vertex limit of the unit
    localparam int MAX_VERTICES_DEF = 64;

    // Control of the in-degree lanes
    typedef struct packed {
        logic clr;  // zero every lane
        logic acc;  // add one where the row bit is set
        logic dec;  // subtract one where the row bit is set and the lane is not zero
    } t_deg_ctrl;

endpackage

@@ design/topological_sort_kahn_unit.sv @@
// Topological sort unit (Kahn's algorithm) over a graph of up to MAX_VERTICES vertices.
// Input channel: one adjacency row per transaction (i_row_vertex, i_row_bits, i_last_row);
//   bit v of the row means an edge from i_row_vertex to v. Rows are taken one per cycle
//   while o_stall is low. The row with i_last_row set fixes the vertex count and starts
//   the sort; o_stall stays high until the last result of that sort is loaded.
// Output channel: one transaction per sorted vertex, in order; the last carries
//   o_final_res and o_acyclic. A graph with no zero in-degree vertex gives a single
//   status transaction with o_has_vertex low.
// Sequence: the in-degree pass reads one adjacency row per vertex and then drains the
//   read; seeding appends every zero in-degree vertex to the ready queue; each emitted
//   vertex is popped, its row read and its successors decremented, and the successors
//   it frees are appended one at a time, as the ready queue accepts one write per cycle.
// A held result stalls the sort only at the next emission; new rows may be taken while
//   the final result waits. Reset returns to row loading with an empty output register;
//   the adjacency memory is not cleared and a row must be written before it is used.
// Depends on tsk_pkg, tsk_ram and tsk_deg.
module topological_sort_kahn_unit #(
    parameter int MAX_VERTICES = tsk_pkg::MAX_VERTICES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Row transactions
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [tsk_pkg::VTX_W-1:0] i_row_vertex,
    input  logic [tsk_pkg::ROW_W-1:0] i_row_bits,
    input  logic                      i_last_row,
    // Result transactions
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [tsk_pkg::VTX_W-1:0] o_vertex,
    output logic                      o_has_vertex,
    output logic                      o_final_res,
    output logic                      o_acyclic
);

    localparam int NV = MAX_VERTICES;
    localparam int AW = $clog2(NV);
    localparam int CW = $clog2(NV + 1);
    localparam int UW = tsk_pkg::VTX_W + 1;

    typedef enum logic [3:0] {
        S_LOAD,
        S_DEG,
        S_DRAIN,
        S_SEED,
        S_POP,
        S_QRD,
        S_DEC,
        S_APPEND,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_n;
    logic [NV-1:0]       r_live;
    logic [CW-1:0]       r_idx;
    logic                r_acc;
    logic [CW-1:0]       r_head;
    logic [CW-1:0]       r_tail;
    logic [CW-1:0]       r_cnt;
    logic [NV-1:0]       r_pend;
    logic                r_seed;
    logic                r_none;
    logic [AW-1:0]       r_v;
    logic                r_o_valid;
    logic [tsk_pkg::VTX_W-1:0] r_o_vertex;
    logic                r_o_has;
    logic                r_o_final;
    logic                r_o_acyclic;

    logic                w_in_acc;
    logic                w_out_free;
    logic [UW-1:0]       w_u_ext;
    logic                w_fits;
    logic [UW-1:0]       w_n_ext;
    logic [CW-1:0]       n_n;
    logic [NV-1:0]       n_live;
    logic [AW-1:0]       w_pick;
    logic [CW:0]         w_cnt_inc;
    logic                w_q_empty;

    logic [NV-1:0]       w_adj_rdata;
    logic [AW-1:0]       w_adj_raddr;
    logic [AW-1:0]       w_q_rdata;
    logic                w_q_we;
    logic [NV-1:0]       w_row_live;
    logic [NV-1:0]       w_zero;
    logic [NV-1:0]       w_freed;
    tsk_pkg::t_deg_ctrl  w_deg_ctrl;

    // Handshake terms
    assign o_stall    = (r_state != S_LOAD);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !r_o_valid || !i_stall;

    // Vertex count from the last row, saturated at the limit
    assign w_u_ext = {1'b0, i_row_vertex};
    assign w_fits  = (w_u_ext < UW'(NV));
    assign w_n_ext = w_fits ? (w_u_ext + UW'(1)) : UW'(NV);
    assign n_n     = w_n_ext[CW-1:0];

    always_comb begin
        for (int i = 0; i < NV; i++) begin
            n_live[i] = (CW'(i) < n_n);
        end
    end

    // Lowest pending vertex goes to the queue first
    always_comb begin
        w_pick = '0;
        for (int i = NV - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                w_pick = AW'(i);
            end
        end
    end

    assign w_cnt_inc = {1'b0, r_cnt} + (CW + 1)'(1);
    assign w_q_empty = (r_head == r_tail);

    // Adjacency rows: written on load, read by row index or by popped vertex
    assign w_adj_raddr = (r_state == S_QRD) ? w_q_rdata : r_idx[AW-1:0];

    tsk_ram #(
        .WIDTH (NV),
        .DEPTH (NV)
    ) u_adj (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && w_fits),
        .i_waddr (i_row_vertex[AW-1:0]),
        .i_wdata (i_row_bits[NV-1:0]),
        .i_raddr (w_adj_raddr),
        .o_rdata (w_adj_rdata)
    );

    // Ready queue: appended at the tail, read at the head
    assign w_q_we = (r_state == S_APPEND) && (r_pend != '0);

    tsk_ram #(
        .WIDTH (AW),
        .DEPTH (NV)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (r_tail[AW-1:0]),
        .i_wdata (w_pick),
        .i_raddr (r_head[AW-1:0]),
        .o_rdata (w_q_rdata)
    );

    // In-degree lanes
    assign w_row_live     = w_adj_rdata & r_live;
    assign w_deg_ctrl.clr = w_in_acc && i_last_row;
    assign w_deg_ctrl.acc = r_acc;
    assign w_deg_ctrl.dec = (r_state == S_DEC);

    tsk_deg #(
        .NV (NV)
    ) u_deg (
        .i_clk   (i_clk),
        .i_ctrl  (w_deg_ctrl),
        .i_row   (w_row_live),
        .i_live  (r_live),
        .o_zero  (w_zero),
        .o_freed (w_freed)
    );

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_acc     <= 1'b0;
            r_head    <= '0;
            r_tail    <= '0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_acc <= (r_state == S_DEG);
            // Drop a taken result unless the emit step reloads the register
            if (r_o_valid && !i_stall && (r_state != S_EMIT)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc && i_last_row) begin
                        r_n     <= n_n;
                        r_live  <= n_live;
                        r_idx   <= '0;
                        r_head  <= '0;
                        r_tail  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DEG;
                    end
                end
                S_DEG: begin
                    r_idx <= r_idx + CW'(1);
                    if (r_idx == r_n - CW'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_SEED;
                end
                S_SEED: begin
                    r_pend  <= w_zero;
                    r_seed  <= 1'b1;
                    r_state <= S_APPEND;
                end
                S_POP: begin
                    if (w_q_empty) begin
                        r_none  <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_head  <= r_head + CW'(1);
                        r_state <= S_QRD;
                    end
                end
                S_QRD: begin
                    r_v     <= w_q_rdata;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_pend  <= w_freed;
                    r_seed  <= 1'b0;
                    r_none  <= 1'b0;
                    r_state <= S_APPEND;
                end
                S_APPEND: begin
                    if (r_pend != '0) begin
                        r_tail <= r_tail + CW'(1);
                        r_pend <= r_pend & (r_pend - NV'(1));
                    end else if (r_seed) begin
                        r_state <= S_POP;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        if (r_none) begin
                            r_o_vertex  <= '0;
                            r_o_has     <= 1'b0;
                            r_o_final   <= 1'b1;
                            r_o_acyclic <= 1'b0;
                            r_state     <= S_LOAD;
                        end else begin
                            r_o_vertex  <= tsk_pkg::VTX_W'(r_v);
                            r_o_has     <= 1'b1;
                            r_o_final   <= w_q_empty;
                            r_o_acyclic <= w_q_empty && (w_cnt_inc == {1'b0, r_n});
                            r_cnt       <= w_cnt_inc[CW-1:0];
                            r_state     <= w_q_empty ? S_LOAD : S_POP;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_valid      = r_o_valid;
    assign o_vertex     = r_o_vertex;
    assign o_has_vertex = r_o_has;
    assign o_final_res  = r_o_final;
    assign o_acyclic    = r_o_acyclic;

    // The queue head never passes the tail
    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("ready queue head passed tail");

    // No more vertices emitted than the graph holds
    a_cnt_le_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> (r_cnt <= r_n))
        else $error("emitted count exceeds vertex count");

    // An acyclic verdict only on a final result that carries a vertex
    a_acyclic_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_acyclic) |-> (o_final_res && o_has_vertex))
        else $error("acyclic flag on a non-final or status result");

    // A freshly loaded status result means nothing was emitted
    a_status_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_valid) && !o_has_vertex) |-> (r_cnt == '0))
        else $error("status result after vertices were emitted");

endmodule

@@ design/tsk_ram.sv @@
// Simple dual-port synchronous memory: one write port and one read port, registered read data.
// Used for the adjacency rows and the ready queue. No package dependency.
module tsk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, and a registered read that returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/tsk_deg.sv @@
// In-degree lanes of the topological sort unit: one counter per vertex, updated a row at a time.
// Depends on tsk_pkg for the lane control struct.
module tsk_deg #(
    parameter int NV = tsk_pkg::MAX_VERTICES_DEF
) (
    input  logic              i_clk,
    input  tsk_pkg::t_deg_ctrl i_ctrl,
    input  logic [NV-1:0]     i_row,
    input  logic [NV-1:0]     i_live,
    output logic [NV-1:0]     o_zero,
    output logic [NV-1:0]     o_freed
);

    localparam int DW = $clog2(NV + 1);

    genvar g;
    generate
        for (g = 0; g < NV; g++) begin : g_lane
            logic [DW-1:0] r_deg;

            // Clear, count an incoming edge, or drop one on a pop
            always_ff @(posedge i_clk) begin
                if (i_ctrl.clr) begin
                    r_deg <= '0;
                end else if (i_ctrl.acc && i_row[g]) begin
                    r_deg <= r_deg + DW'(1);
                end else if (i_ctrl.dec && i_row[g] && (r_deg != '0)) begin
                    r_deg <= r_deg - DW'(1);
                end
            end

            // Live vertices with no incoming edge left
            assign o_zero[g]  = i_live[g] && (r_deg == '0);
            // Row bits whose lane is at one or already zero, so that a decrement leaves them at zero
            assign o_freed[g] = i_row[g] && ((r_deg == '0) || (r_deg == DW'(1)));
        end
    endgenerate

endmodule
